FILE: hdl/component_color_transform_core_macros.svh
// Assertion macros shared by the color transform checker.
`ifndef COMPONENT_COLOR_TRANSFORM_CORE_MACROS_SVH
`define COMPONENT_COLOR_TRANSFORM_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define CCT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define CCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/cct_pkg.sv
// Shared types, constants and configuration layout of the color transform.
package cct_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 21;
    localparam int COEF_FRAC_BITS_DEF = 16;
    localparam int NUM_COMP           = 3;
    localparam int OUT_WIDTH          = 23;
    localparam int DC_WIDTH           = 21;
    localparam int SHIFT_WIDTH        = 6;
    localparam int SHAMT_WIDTH        = 5;
    localparam int RND_WIDTH          = 16;
    localparam int MAX_SHIFT          = 16;
    localparam int CFG_ADDR_WIDTH     = 3;
    localparam int CFG_DATA_WIDTH     = 23;
    localparam int OUT_TDATA_WIDTH    = ((NUM_COMP * OUT_WIDTH + 7) / 8) * 8;

    localparam logic signed [SHIFT_WIDTH-1:0] SHIFT_HI = SHIFT_WIDTH'(MAX_SHIFT);
    localparam logic signed [SHIFT_WIDTH-1:0] SHIFT_LO = SHIFT_WIDTH'(-MAX_SHIFT);
    localparam logic [SHAMT_WIDTH-1:0]        SHAMT_MAX = SHAMT_WIDTH'(MAX_SHIFT);

    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        REG_DIRECTION  = 3'd0,
        REG_REVERSIBLE = 3'd1,
        REG_FINALIZE   = 3'd2,
        REG_DC_OFFSET  = 3'd3,
        REG_MIN_VALUE  = 3'd4,
        REG_MAX_VALUE  = 3'd5,
        REG_DOWN_SHIFT = 3'd6,
        REG_ROUND_OFS  = 3'd7
    } cct_reg_t;

    typedef struct packed {
        logic                          direction;
        logic                          reversible;
        logic                          finalize;
        logic signed [DC_WIDTH-1:0]    dc_offset;
        logic signed [OUT_WIDTH-1:0]   min_value;
        logic signed [OUT_WIDTH-1:0]   max_value;
        logic signed [SHIFT_WIDTH-1:0] down_shift;
        logic [RND_WIDTH-1:0]          rounding_offset;
    } cct_cfg_t;

    localparam cct_cfg_t CFG_RESET = '{
        direction:       1'b0,
        reversible:      1'b1,
        finalize:        1'b0,
        dc_offset:       '0,
        min_value:       {1'b1, {(OUT_WIDTH-1){1'b0}}},
        max_value:       {1'b0, {(OUT_WIDTH-1){1'b1}}},
        down_shift:      '0,
        rounding_offset: '0
    };

endpackage

FILE: hdl/component_color_transform_core.sv
// Top level of the RGB/YCbCr color transform: register file and five-stage pipeline.
// One pixel enters per clock unless the output stalls, with one stage each for
// the coefficient products, the product sum, the rounding to integer, the finalize shift,
// and the DC offset with clamp. Every stage has its own valid bit and takes a new beat
// whenever it is empty or its successor moves, so bubbles close up and the input keeps
// accepting while a finished result waits at the output, until every stage is full.
// s_axis_tready follows m_axis_tready combinationally through the stages. Configuration
// must be written only while the pipeline is empty; the block itself does not enforce it.
module component_color_transform_core import cct_pkg::*; #(
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        cfg_wr_en,
    input  logic [CFG_ADDR_WIDTH-1:0]                   cfg_addr,
    input  logic [CFG_DATA_WIDTH-1:0]                   cfg_wr_data,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // comp0_in, comp1_in, comp2_in, zero padding
    input  logic [((3 * SAMPLE_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,
    input  logic                                        s_axis_tlast,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // comp0_out, comp1_out, comp2_out, zero padding
    output logic [OUT_TDATA_WIDTH-1:0]                  m_axis_tdata,
    output logic                                        m_axis_tlast
);

    localparam int PW = SAMPLE_WIDTH + COEF_FRAC_BITS + 2;
    localparam int XW = SAMPLE_WIDTH + 4;

    cct_cfg_t                    cfg_reg;
    logic signed [SAMPLE_WIDTH-1:0] comp0_in, comp1_in, comp2_in;
    logic signed [PW-1:0]        prod     [NUM_COMP][NUM_COMP];
    logic signed [XW-1:0]        rev      [NUM_COMP];
    logic signed [XW-1:0]        xval     [NUM_COMP];
    logic signed [OUT_WIDTH-1:0] comp_out [NUM_COMP];
    logic                        mult_valid, mult_ready, mult_last;
    logic                        round_valid, round_ready, round_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            case (cct_reg_t'(cfg_addr))
                REG_DIRECTION:  cfg_reg.direction       <= cfg_wr_data[0];
                REG_REVERSIBLE: cfg_reg.reversible      <= cfg_wr_data[0];
                REG_FINALIZE:   cfg_reg.finalize        <= cfg_wr_data[0];
                REG_DC_OFFSET:  cfg_reg.dc_offset       <= cfg_wr_data[DC_WIDTH-1:0];
                REG_MIN_VALUE:  cfg_reg.min_value       <= cfg_wr_data[OUT_WIDTH-1:0];
                REG_MAX_VALUE:  cfg_reg.max_value       <= cfg_wr_data[OUT_WIDTH-1:0];
                REG_DOWN_SHIFT: cfg_reg.down_shift      <= cfg_wr_data[SHIFT_WIDTH-1:0];
                REG_ROUND_OFS:  cfg_reg.rounding_offset <= cfg_wr_data[RND_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign comp0_in = s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign comp1_in = s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    assign comp2_in = s_axis_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH];

    cct_mult #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .comp0     (comp0_in),
        .comp1     (comp1_in),
        .comp2     (comp2_in),
        .in_last   (s_axis_tlast),
        .out_valid (mult_valid),
        .out_ready (mult_ready),
        .prod_o    (prod),
        .rev_o     (rev),
        .out_last  (mult_last)
    );

    cct_round #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (mult_valid),
        .in_ready  (mult_ready),
        .prod_i    (prod),
        .rev_i     (rev),
        .in_last   (mult_last),
        .out_valid (round_valid),
        .out_ready (round_ready),
        .x_o       (xval),
        .out_last  (round_last)
    );

    cct_finalize #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_finalize (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (round_valid),
        .in_ready  (round_ready),
        .x_i       (xval),
        .in_last   (round_last),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .comp_o    (comp_out),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_TDATA_WIDTH'({comp_out[2], comp_out[1], comp_out[0]});

endmodule

FILE: hdl/cct_mult.sv
// First pipeline stage: coefficient products and the reversible integer transform.
module cct_mult import cct_pkg::*; #(
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  cct_cfg_t                                      cfg,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]                comp0,
    input  logic signed [SAMPLE_WIDTH-1:0]                comp1,
    input  logic signed [SAMPLE_WIDTH-1:0]                comp2,
    input  logic                                          in_last,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic signed [SAMPLE_WIDTH+COEF_FRAC_BITS+1:0] prod_o [NUM_COMP][NUM_COMP],
    output logic signed [SAMPLE_WIDTH+3:0]                rev_o [NUM_COMP],
    output logic                                          out_last
);

    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int PW = SAMPLE_WIDTH + CW;
    localparam int XW = SAMPLE_WIDTH + 4;

    localparam longint K299_1000  = ((longint'(299) << COEF_FRAC_BITS) + 500) / 1000;
    localparam longint K587_1000  = ((longint'(587) << COEF_FRAC_BITS) + 500) / 1000;
    localparam longint K114_1000  = ((longint'(114) << COEF_FRAC_BITS) + 500) / 1000;
    localparam longint KHALF      = ((longint'(1) << COEF_FRAC_BITS) + 1) / 2;
    localparam longint K299_1772  = ((longint'(299) << COEF_FRAC_BITS) + 886) / 1772;
    localparam longint K587_1772  = ((longint'(587) << COEF_FRAC_BITS) + 886) / 1772;
    localparam longint K587_1402  = ((longint'(587) << COEF_FRAC_BITS) + 701) / 1402;
    localparam longint K114_1402  = ((longint'(114) << COEF_FRAC_BITS) + 701) / 1402;
    localparam longint KONE       = longint'(1) << COEF_FRAC_BITS;
    localparam longint K1402_1000 = ((longint'(1402) << COEF_FRAC_BITS) + 500) / 1000;
    localparam longint K1772_1000 = ((longint'(1772) << COEF_FRAC_BITS) + 500) / 1000;
    localparam longint K714136    =
        ((longint'(714136) << COEF_FRAC_BITS) + 500000) / 1000000;
    localparam longint K344136    =
        ((longint'(344136) << COEF_FRAC_BITS) + 500000) / 1000000;

    localparam logic signed [CW-1:0] C_Y_R   = CW'(K299_1000);
    localparam logic signed [CW-1:0] C_Y_G   = CW'(K587_1000);
    localparam logic signed [CW-1:0] C_Y_B   = CW'(K114_1000);
    localparam logic signed [CW-1:0] C_HALF  = CW'(KHALF);
    localparam logic signed [CW-1:0] C_CB_R  = CW'(-K299_1772);
    localparam logic signed [CW-1:0] C_CB_G  = CW'(-K587_1772);
    localparam logic signed [CW-1:0] C_CR_G  = CW'(-K587_1402);
    localparam logic signed [CW-1:0] C_CR_B  = CW'(-K114_1402);
    localparam logic signed [CW-1:0] C_ONE   = CW'(KONE);
    localparam logic signed [CW-1:0] C_R_CR  = CW'(K1402_1000);
    localparam logic signed [CW-1:0] C_G_CR  = CW'(-K714136);
    localparam logic signed [CW-1:0] C_G_CB  = CW'(-K344136);
    localparam logic signed [CW-1:0] C_B_CB  = CW'(K1772_1000);

    logic signed [CW-1:0]           coef [NUM_COMP][NUM_COMP];
    logic signed [SAMPLE_WIDTH-1:0] opnd [NUM_COMP];
    logic signed [PW-1:0]           prod_next [NUM_COMP][NUM_COMP];
    logic signed [PW-1:0]           prod_reg  [NUM_COMP][NUM_COMP];
    logic signed [XW-1:0]           rev_next  [NUM_COMP];
    logic signed [XW-1:0]           rev_reg   [NUM_COMP];
    logic signed [XW-1:0]           ax, bx, cx, quarter, g;
    logic                           valid_reg;
    logic                           last_reg;

    assign opnd[0] = comp0;
    assign opnd[1] = comp1;
    assign opnd[2] = comp2;

    // Each result lane is one three-term linear combination of the inputs.
    always_comb begin
        if (!cfg.direction) begin
            coef[0][0] = C_Y_R;  coef[0][1] = C_Y_G;  coef[0][2] = C_Y_B;
            coef[1][0] = C_CB_R; coef[1][1] = C_CB_G; coef[1][2] = C_HALF;
            coef[2][0] = C_HALF; coef[2][1] = C_CR_G; coef[2][2] = C_CR_B;
        end else begin
            coef[0][0] = C_ONE;  coef[0][1] = '0;     coef[0][2] = C_R_CR;
            coef[1][0] = C_ONE;  coef[1][1] = C_G_CB; coef[1][2] = C_G_CR;
            coef[2][0] = C_ONE;  coef[2][1] = C_B_CB; coef[2][2] = '0;
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_COMP; k++) begin
            for (int j = 0; j < NUM_COMP; j++) begin
                prod_next[k][j] = PW'(coef[k][j]) * PW'(opnd[j]);
            end
        end
    end

    assign ax      = XW'(comp0);
    assign bx      = XW'(comp1);
    assign cx      = XW'(comp2);
    assign quarter = (bx + cx) >>> 2;
    assign g       = ax - quarter;

    always_comb begin
        if (!cfg.direction) begin
            rev_next[0] = (ax + (bx <<< 1) + cx) >>> 2;
            rev_next[1] = cx - bx;
            rev_next[2] = ax - bx;
        end else begin
            rev_next[0] = cx + g;
            rev_next[1] = g;
            rev_next[2] = bx + g;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            prod_reg <= prod_next;
            rev_reg  <= rev_next;
            last_reg <= in_last;
        end
    end

    assign out_valid = valid_reg;
    assign prod_o    = prod_reg;
    assign rev_o     = rev_reg;
    assign out_last  = last_reg;

endmodule

FILE: hdl/cct_round.sv
// Second and third pipeline stages: product sum, then rounding or truncation to integer.
module cct_round import cct_pkg::*; #(
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  cct_cfg_t                                      cfg,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic signed [SAMPLE_WIDTH+COEF_FRAC_BITS+1:0] prod_i [NUM_COMP][NUM_COMP],
    input  logic signed [SAMPLE_WIDTH+3:0]                rev_i [NUM_COMP],
    input  logic                                          in_last,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic signed [SAMPLE_WIDTH+3:0]                x_o [NUM_COMP],
    output logic                                          out_last
);

    localparam int PW   = SAMPLE_WIDTH + COEF_FRAC_BITS + 2;
    localparam int SUMW = PW + 2;
    localparam int BW   = SUMW + 1;
    localparam int XW   = SAMPLE_WIDTH + 4;

    localparam logic signed [BW-1:0] ROUND_BIAS = BW'(longint'(1) << (COEF_FRAC_BITS - 1));
    localparam logic signed [BW-1:0] TRUNC_BIAS = BW'((longint'(1) << COEF_FRAC_BITS) - 1);

    logic signed [SUMW-1:0] sum_next [NUM_COMP];
    logic signed [SUMW-1:0] sum_reg  [NUM_COMP];
    logic signed [XW-1:0]   rev_reg  [NUM_COMP];
    logic signed [BW-1:0]   bias     [NUM_COMP];
    logic signed [BW-1:0]   scaled   [NUM_COMP];
    logic signed [XW-1:0]   x_next   [NUM_COMP];
    logic signed [XW-1:0]   x_reg    [NUM_COMP];
    logic                   valid_a_reg, valid_b_reg;
    logic                   last_a_reg, last_b_reg;
    logic                   ready_b;
    logic                   truncate;

    always_comb begin
        for (int k = 0; k < NUM_COMP; k++) begin
            sum_next[k] = SUMW'(prod_i[k][0]) + SUMW'(prod_i[k][1]) + SUMW'(prod_i[k][2]);
        end
    end

    // A finalized irreversible inverse truncates toward zero; everything else
    // rounds to nearest with halves going up.
    assign truncate = cfg.direction && !cfg.reversible && cfg.finalize;

    always_comb begin
        for (int k = 0; k < NUM_COMP; k++) begin
            if (truncate) begin
                bias[k] = sum_reg[k][SUMW-1] ? TRUNC_BIAS : '0;
            end else begin
                bias[k] = ROUND_BIAS;
            end
            scaled[k] = (BW'(sum_reg[k]) + bias[k]) >>> COEF_FRAC_BITS;
            x_next[k] = cfg.reversible ? rev_reg[k] : XW'(scaled[k]);
        end
    end

    assign ready_b  = !valid_b_reg || out_ready;
    assign in_ready = !valid_a_reg || ready_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                valid_a_reg <= in_valid;
            end
            if (ready_b) begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            sum_reg    <= sum_next;
            rev_reg    <= rev_i;
            last_a_reg <= in_last;
        end
        if (ready_b && valid_a_reg) begin
            x_reg      <= x_next;
            last_b_reg <= last_a_reg;
        end
    end

    assign out_valid = valid_b_reg;
    assign x_o       = x_reg;
    assign out_last  = last_b_reg;

endmodule

FILE: hdl/cct_finalize.sv
// Fourth and fifth pipeline stages: finalize shift, then DC offset and clamp.
module cct_finalize import cct_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  cct_cfg_t                       cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH+3:0] x_i [NUM_COMP],
    input  logic                           in_last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [OUT_WIDTH-1:0]    comp_o [NUM_COMP],
    output logic                           out_last
);

    localparam int XW = SAMPLE_WIDTH + 4;
    localparam int FW = XW + 18;
    localparam int DW = FW + 1;

    logic                          fin_on, fin_shift;
    logic signed [SHIFT_WIDTH-1:0] neg_shift;
    logic [SHAMT_WIDTH-1:0]        shamt;
    logic                          shift_right, shift_left;
    logic signed [FW-1:0]          rnd_ext;
    logic signed [FW-1:0]          xf       [NUM_COMP];
    logic signed [FW-1:0]          f_next   [NUM_COMP];
    logic signed [FW-1:0]          f_reg    [NUM_COMP];
    logic signed [DW-1:0]          y        [NUM_COMP];
    logic signed [OUT_WIDTH-1:0]   out_next [NUM_COMP];
    logic signed [OUT_WIDTH-1:0]   out_reg  [NUM_COMP];
    logic signed [DW-1:0]          dc_ext, min_ext, max_ext;
    logic                          valid_a_reg, valid_b_reg;
    logic                          last_a_reg, last_b_reg;
    logic                          ready_b;

    assign fin_on    = cfg.direction && cfg.finalize;
    assign fin_shift = fin_on && !cfg.reversible;
    assign neg_shift = -cfg.down_shift;

    // Shift amounts beyond sixteen in either direction saturate.
    always_comb begin
        shift_right = 1'b0;
        shift_left  = 1'b0;
        shamt       = '0;
        if (cfg.down_shift > SHIFT_HI) begin
            shift_right = 1'b1;
            shamt       = SHAMT_MAX;
        end else if (cfg.down_shift < SHIFT_LO) begin
            shift_left  = 1'b1;
            shamt       = SHAMT_MAX;
        end else if (cfg.down_shift > 0) begin
            shift_right = 1'b1;
            shamt       = cfg.down_shift[SHAMT_WIDTH-1:0];
        end else if (cfg.down_shift < 0) begin
            shift_left  = 1'b1;
            shamt       = neg_shift[SHAMT_WIDTH-1:0];
        end
    end

    assign rnd_ext = FW'($signed({1'b0, cfg.rounding_offset}));

    always_comb begin
        for (int k = 0; k < NUM_COMP; k++) begin
            xf[k] = FW'(x_i[k]);
            if (fin_shift && shift_right) begin
                f_next[k] = (xf[k] + rnd_ext) >>> shamt;
            end else if (fin_shift && shift_left) begin
                f_next[k] = xf[k] <<< shamt;
            end else begin
                f_next[k] = xf[k];
            end
        end
    end

    assign dc_ext  = DW'(cfg.dc_offset);
    assign min_ext = DW'(cfg.min_value);
    assign max_ext = DW'(cfg.max_value);

    // The lower bound is applied last, so it wins when the bounds cross.
    always_comb begin
        for (int k = 0; k < NUM_COMP; k++) begin
            y[k] = DW'(f_reg[k]);
            if (fin_on) begin
                y[k] = y[k] + dc_ext;
                if (y[k] > max_ext) begin
                    y[k] = max_ext;
                end
                if (y[k] < min_ext) begin
                    y[k] = min_ext;
                end
            end
            out_next[k] = y[k][OUT_WIDTH-1:0];
        end
    end

    assign ready_b  = !valid_b_reg || out_ready;
    assign in_ready = !valid_a_reg || ready_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                valid_a_reg <= in_valid;
            end
            if (ready_b) begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            f_reg      <= f_next;
            last_a_reg <= in_last;
        end
        if (ready_b && valid_a_reg) begin
            out_reg    <= out_next;
            last_b_reg <= last_a_reg;
        end
    end

    assign out_valid = valid_b_reg;
    assign comp_o    = out_reg;
    assign out_last  = last_b_reg;

endmodule

FILE: hdl/cct_checker.sv
// Port-level checker for the color transform, bound to the top level.
`include "component_color_transform_core_macros.svh"

module cct_checker import cct_pkg::*; (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata,
    input logic                       m_axis_tlast
);

    // Reset empties the whole pipeline, so no beat is offered right after it.
    `CCT_ASSERT_NEXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_axis_tvalid, "beat offered after reset")

    // When the output stage is free, every stage behind it is free to move.
    `CCT_ASSERT_IMPLY(a_ready_when_drained, aclk, aresetn, !m_axis_tvalid || m_axis_tready, s_axis_tready, "input stalled with free output")

    `CCT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled beat changed")

endmodule

bind component_color_transform_core cct_checker u_cct_checker (.*);

FILE: tb/sv/component_color_transform_core_tb.sv
// Self-checking testbench for the RGB/YCbCr color transform core in all four modes.
module component_color_transform_core_tb;
    import cct_pkg::*;

    localparam int SW             = SAMPLE_WIDTH_DEF;
    localparam int FRAC           = COEF_FRAC_BITS_DEF;
    localparam int IN_TDATA_WIDTH = ((NUM_COMP * SW + 7) / 8) * 8;
    localparam int LIMIT_CYCLES   = 200000;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_TAIL     = 12;
    localparam int PHASE_PIXELS   = 125;
    localparam int RANDOM_PHASES  = 12;

    localparam logic signed [SW-1:0]       S_MAX  = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0]       S_MIN  = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [DC_WIDTH-1:0] DC_MAX = {1'b0, {(DC_WIDTH-1){1'b1}}};
    localparam logic signed [DC_WIDTH-1:0] DC_MIN = {1'b1, {(DC_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic                 row_end;
        logic signed [SW-1:0] c2;
        logic signed [SW-1:0] c1;
        logic signed [SW-1:0] c0;
    } pixel_t;

    typedef struct packed {
        logic                 row_end;
        logic [OUT_WIDTH-1:0] c2;
        logic [OUT_WIDTH-1:0] c1;
        logic [OUT_WIDTH-1:0] c0;
    } color_t;

    logic                        aclk          = 1'b0;
    logic                        aresetn       = 1'b0;
    logic                        cfg_wr_en     = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0]   cfg_addr      = '0;
    logic [CFG_DATA_WIDTH-1:0]   cfg_wr_data   = '0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [IN_TDATA_WIDTH-1:0]   s_axis_tdata  = '0;
    logic                        s_axis_tlast  = 1'b0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [OUT_TDATA_WIDTH-1:0]  m_axis_tdata;
    logic                        m_axis_tlast;

    cct_cfg_t shadow_cfg = CFG_RESET;
    color_t   pending_colors[$];
    int       mismatches    = 0;
    int       beats_out     = 0;
    int       cycle_count   = 0;
    int       hold_requests = 0;
    int       hold_served   = 0;
    int       hold_left     = 0;
    logic     steady        = 1'b0;

    component_color_transform_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Transform predictor
    // ------------------------------------------------------------------

    // Nearest fixed-point value of num/den.
    function automatic longint coef(longint num, longint den);
        return ((num <<< FRAC) + den / 2) / den;
    endfunction

    function automatic longint round_fixed(longint v);
        return (v + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic longint finalize_sample(cct_cfg_t cfg, longint x, bit scaled);
        longint ds;
        if (scaled) begin
            ds = longint'(cfg.down_shift);
            if (ds > MAX_SHIFT) ds = longint'(MAX_SHIFT);
            if (ds < -MAX_SHIFT) ds = -longint'(MAX_SHIFT);
            if (ds > 0)
                x = (x + longint'(cfg.rounding_offset)) >>> ds;
            else if (ds < 0)
                x = x <<< (-ds);
        end
        x = x + longint'(cfg.dc_offset);
        if (x > longint'(cfg.max_value)) x = longint'(cfg.max_value);
        // The lower bound wins when the bounds are crossed.
        if (x < longint'(cfg.min_value)) x = longint'(cfg.min_value);
        return x;
    endfunction

    function automatic color_t transform_pixel(cct_cfg_t cfg, pixel_t px);
        longint a, b, c, g, y, t;
        longint o[NUM_COMP];
        longint fx[NUM_COMP];
        color_t res;
        a = longint'(px.c0);
        b = longint'(px.c1);
        c = longint'(px.c2);
        if (!cfg.direction) begin
            if (cfg.reversible) begin
                o[0] = (a + 2 * b + c) >>> 2;
                o[1] = c - b;
                o[2] = a - b;
            end else begin
                o[0] = round_fixed(coef(299, 1000) * a + coef(587, 1000) * b
                                   + coef(114, 1000) * c);
                o[1] = round_fixed(coef(1, 2) * c - coef(299, 1772) * a
                                   - coef(587, 1772) * b);
                o[2] = round_fixed(coef(1, 2) * a - coef(587, 1402) * b
                                   - coef(114, 1402) * c);
            end
        end else if (cfg.reversible) begin
            g = a - ((b + c) >>> 2);
            o[0] = c + g;
            o[1] = g;
            o[2] = b + g;
            if (cfg.finalize) begin
                for (int i = 0; i < NUM_COMP; i++) o[i] = finalize_sample(cfg, o[i], 1'b0);
            end
        end else begin
            y = a <<< FRAC;
            fx[0] = y + coef(1402, 1000) * c;
            fx[1] = y - coef(714136, 1000000) * c - coef(344136, 1000000) * b;
            fx[2] = y + coef(1772, 1000) * b;
            for (int i = 0; i < NUM_COMP; i++) begin
                if (cfg.finalize) begin
                    // The finalize path starts from the value truncated toward zero.
                    t = (fx[i] < 0) ? -((-fx[i]) >>> FRAC) : (fx[i] >>> FRAC);
                    o[i] = finalize_sample(cfg, t, 1'b1);
                end else begin
                    o[i] = round_fixed(fx[i]);
                end
            end
        end
        res.c0      = OUT_WIDTH'(o[0]);
        res.c1      = OUT_WIDTH'(o[1]);
        res.c2      = OUT_WIDTH'(o[2]);
        res.row_end = px.row_end;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result side: ready generator and checker
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(99) >= 12);
        end
    end

    task automatic note_error(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endtask

    // Inputs only change at rising edges, so the falling edge sees what the next edge takes.
    always @(negedge aclk) begin
        color_t got;
        color_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.c0      = m_axis_tdata[OUT_WIDTH-1:0];
            got.c1      = m_axis_tdata[2*OUT_WIDTH-1:OUT_WIDTH];
            got.c2      = m_axis_tdata[3*OUT_WIDTH-1:2*OUT_WIDTH];
            got.row_end = m_axis_tlast;
            if (pending_colors.size() == 0) begin
                note_error($sformatf("beat %0d: result with no pixel outstanding", beats_out));
            end else begin
                want = pending_colors.pop_front();
                if (got.c0 !== want.c0)
                    note_error($sformatf("beat %0d comp0: expected %0d, got %0d", beats_out,
                                         $signed(want.c0), $signed(got.c0)));
                if (got.c1 !== want.c1)
                    note_error($sformatf("beat %0d comp1: expected %0d, got %0d", beats_out,
                                         $signed(want.c1), $signed(got.c1)));
                if (got.c2 !== want.c2)
                    note_error($sformatf("beat %0d comp2: expected %0d, got %0d", beats_out,
                                         $signed(want.c2), $signed(got.c2)));
                if (got.row_end !== want.row_end)
                    note_error($sformatf("beat %0d row end: expected %0b, got %0b", beats_out,
                                         want.row_end, got.row_end));
            end
            beats_out++;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    task automatic send_pixel(input pixel_t px);
        logic took;
        while (!steady && $urandom_range(99) < 12) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_WIDTH'({px.c2, px.c1, px.c0});
        s_axis_tlast  <= px.row_end;
        do begin
            @(negedge aclk);
            took = s_axis_tready;
            @(posedge aclk);
        end while (!took);
        pending_colors.push_back(transform_pixel(shadow_cfg, px));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge aclk);
    endtask

    // Bits above the register width carry random junk about half the time.
    task automatic write_reg(input cct_reg_t idx, input logic [CFG_DATA_WIDTH-1:0] val,
                             input int width);
        logic [CFG_DATA_WIDTH-1:0] keep;
        logic [CFG_DATA_WIDTH-1:0] junk;
        keep = CFG_DATA_WIDTH'((64'd1 << width) - 64'd1);
        junk = ($urandom_range(1) == 1) ? (CFG_DATA_WIDTH'($urandom) & ~keep) : '0;
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= (val & keep) | junk;
        @(posedge aclk);
    endtask

    task automatic program_config(input cct_cfg_t c);
        wait_drained();
        write_reg(REG_DIRECTION,  CFG_DATA_WIDTH'(c.direction), 1);
        write_reg(REG_REVERSIBLE, CFG_DATA_WIDTH'(c.reversible), 1);
        write_reg(REG_FINALIZE,   CFG_DATA_WIDTH'(c.finalize), 1);
        write_reg(REG_DC_OFFSET,  CFG_DATA_WIDTH'(c.dc_offset), DC_WIDTH);
        write_reg(REG_MIN_VALUE,  CFG_DATA_WIDTH'(c.min_value), OUT_WIDTH);
        write_reg(REG_MAX_VALUE,  CFG_DATA_WIDTH'(c.max_value), OUT_WIDTH);
        write_reg(REG_DOWN_SHIFT, CFG_DATA_WIDTH'(c.down_shift), SHIFT_WIDTH);
        write_reg(REG_ROUND_OFS,  CFG_DATA_WIDTH'(c.rounding_offset), RND_WIDTH);
        cfg_wr_en  <= 1'b0;
        shadow_cfg = c;
    endtask

    function automatic pixel_t mk_pixel(logic signed [SW-1:0] a, logic signed [SW-1:0] b,
                                        logic signed [SW-1:0] c, logic last);
        pixel_t px;
        px.c0      = a;
        px.c1      = b;
        px.c2      = c;
        px.row_end = last;
        return px;
    endfunction

    function automatic logic signed [SW-1:0] random_sample();
        case ($urandom_range(9))
            0: return S_MAX;
            1: return S_MIN;
            2, 3, 4: return SW'($signed($urandom_range(2000)) - 1000);
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        return mk_pixel(random_sample(), random_sample(), random_sample(),
                        $urandom_range(7) == 0);
    endfunction

    function automatic cct_cfg_t random_config();
        cct_cfg_t c;
        int lo;
        c.direction  = $urandom_range(99) < 65;
        c.reversible = 1'($urandom_range(1));
        c.finalize   = $urandom_range(3) != 0;
        case ($urandom_range(4))
            0: c.dc_offset = DC_MAX;
            1: c.dc_offset = DC_MIN;
            2: c.dc_offset = DC_WIDTH'($signed($urandom_range(512)) - 256);
            default: c.dc_offset = DC_WIDTH'($urandom);
        endcase
        lo = $signed($urandom_range(1 << 22)) - (1 << 21);
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                c.min_value = CFG_RESET.min_value;
                c.max_value = CFG_RESET.max_value;
            end
            4, 5, 6, 7: begin
                c.min_value = OUT_WIDTH'(lo);
                c.max_value = OUT_WIDTH'(lo + $signed($urandom_range(1 << 20)));
            end
            8: begin
                // Crossed bounds.
                c.min_value = OUT_WIDTH'(lo + 1000);
                c.max_value = OUT_WIDTH'(lo);
            end
            default: begin
                c.min_value = OUT_WIDTH'($urandom);
                c.max_value = OUT_WIDTH'($urandom);
            end
        endcase
        if ($urandom_range(4) != 0)
            c.down_shift = SHIFT_WIDTH'($signed($urandom_range(2 * MAX_SHIFT)) - MAX_SHIFT);
        else
            c.down_shift = SHIFT_WIDTH'($urandom);
        case ($urandom_range(4))
            0: c.rounding_offset = '0;
            1: c.rounding_offset = '1;
            default: c.rounding_offset = RND_WIDTH'($urandom);
        endcase
        return c;
    endfunction

    task automatic run_random_phase(input int count, input bit pause_midway);
        program_config(random_config());
        for (int i = 0; i < count; i++) begin
            if (pause_midway && i == count / 2) wait_drained();
            send_pixel(random_pixel());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers as they come out of reset: forward reversible.
    task automatic test_reset_defaults();
        send_pixel(mk_pixel(S_MAX, S_MAX, S_MAX, 1'b0));
        send_pixel(mk_pixel(S_MIN, S_MIN, S_MIN, 1'b1));
        send_pixel(mk_pixel(S_MAX, S_MIN, S_MAX, 1'b0));
        send_pixel(mk_pixel(SW'(0), SW'(-1), SW'(1), 1'b1));
    endtask

    // Finalize settings are set but must have no effect going forward.
    task automatic test_forward_irreversible();
        cct_cfg_t c;
        c = CFG_RESET;
        c.reversible = 1'b0;
        c.finalize   = 1'b1;
        c.dc_offset  = DC_MAX;
        c.down_shift = SHIFT_HI;
        program_config(c);
        send_pixel(mk_pixel(S_MAX, S_MAX, S_MAX, 1'b0));
        send_pixel(mk_pixel(S_MIN, S_MIN, S_MIN, 1'b0));
        send_pixel(mk_pixel(S_MIN, S_MAX, S_MIN, 1'b1));
        send_pixel(mk_pixel(SW'(1), SW'(0), SW'(-1), 1'b0));
    endtask

    task automatic test_inverse_reversible_clamp();
        cct_cfg_t c;
        c = CFG_RESET;
        c.direction = 1'b1;
        c.finalize  = 1'b1;
        c.dc_offset = DC_WIDTH'(-37);
        c.min_value = OUT_WIDTH'(-100);
        c.max_value = OUT_WIDTH'(100);
        program_config(c);
        send_pixel(mk_pixel(S_MAX, S_MIN, S_MIN, 1'b0));
        send_pixel(mk_pixel(S_MIN, S_MAX, S_MAX, 1'b0));
        send_pixel(mk_pixel(SW'(5), SW'(3), SW'(-2), 1'b1));
        c.min_value = OUT_WIDTH'(500);
        c.max_value = OUT_WIDTH'(-500);
        program_config(c);
        send_pixel(mk_pixel(SW'(0), SW'(0), SW'(0), 1'b0));
    endtask

    task automatic test_inverse_irreversible_shift();
        cct_cfg_t c;
        c = CFG_RESET;
        c.direction  = 1'b1;
        c.reversible = 1'b0;
        program_config(c);
        send_pixel(mk_pixel(S_MAX, S_MAX, S_MAX, 1'b0));
        send_pixel(mk_pixel(S_MIN, S_MIN, S_MIN, 1'b0));
        send_pixel(mk_pixel(SW'(0), S_MAX, S_MIN, 1'b1));
        c.finalize        = 1'b1;
        c.down_shift      = SHIFT_HI;
        c.rounding_offset = '1;
        c.dc_offset       = DC_MAX;
        program_config(c);
        send_pixel(mk_pixel(S_MAX, S_MAX, S_MIN, 1'b0));
        send_pixel(mk_pixel(S_MIN, S_MIN, S_MAX, 1'b0));
        // Shift amounts past the legal range saturate.
        c.down_shift      = SHIFT_WIDTH'(31);
        c.rounding_offset = '0;
        c.dc_offset       = DC_MIN;
        program_config(c);
        send_pixel(mk_pixel(S_MAX, SW'(0), S_MAX, 1'b1));
        c.down_shift = SHIFT_LO;
        c.dc_offset  = '0;
        program_config(c);
        send_pixel(mk_pixel(S_MAX, S_MAX, S_MAX, 1'b0));
        c.down_shift = SHIFT_WIDTH'(-32);
        program_config(c);
        send_pixel(mk_pixel(S_MIN, S_MIN, S_MIN, 1'b1));
    endtask

    // The first phase also stops sending halfway until the pipeline is empty.
    task automatic test_random_phases();
        for (int p = 0; p < RANDOM_PHASES; p++) run_random_phase(PHASE_PIXELS, p == 0);
    endtask

    // The result side stalls long enough for the pipeline to fill and block the input.
    task automatic test_output_stall();
        program_config(random_config());
        for (int i = 0; i < PHASE_PIXELS; i++) begin
            if (i == 10) hold_requests <= hold_requests + 1;
            send_pixel(random_pixel());
        end
    endtask

    task automatic test_steady_stream();
        steady <= 1'b1;
        run_random_phase(PHASE_PIXELS, 1'b0);
        steady <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_forward_irreversible();
        test_inverse_reversible_clamp();
        test_inverse_irreversible_shift();
        test_random_phases();
        test_output_stall();
        test_steady_stream();
        wait_drained();
        repeat (DRAIN_TAIL) @(posedge aclk);
        if (mismatches == 0 && pending_colors.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: component_color_transform_core.f
+incdir+hdl
hdl/cct_pkg.sv
hdl/cct_mult.sv
hdl/cct_round.sv
hdl/cct_finalize.sv
hdl/component_color_transform_core.sv
hdl/cct_checker.sv
tb/sv/component_color_transform_core_tb.sv
